>>> sv/tmrc_pkg.sv
// Shared types, codes and a helper function for the timed motion ramp controller.
package tmrc_pkg;

    localparam int KIND_W     = 2;
    localparam int MOTION_W   = 3;
    localparam int SPEED_W    = 8;
    localparam int DUR_W      = 24;
    localparam int ELAPSED_W  = 25;
    localparam int DRIVE_W    = 3;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [MOTION_W-1:0]  motion_t;
    typedef logic [SPEED_W-1:0]   speed_t;
    typedef logic [DUR_W-1:0]     dur_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [DRIVE_W-1:0]   drive_t;

    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_MOVE = 2'd1;
    localparam kind_t KIND_STOP = 2'd2;

    localparam motion_t MOTION_STOP       = 3'd0;
    localparam motion_t MOTION_FORWARD    = 3'd1;
    localparam motion_t MOTION_BACKWARD   = 3'd2;
    localparam motion_t MOTION_LEFT       = 3'd3;
    localparam motion_t MOTION_RIGHT      = 3'd4;
    localparam motion_t MOTION_SPIN_LEFT  = 3'd5;
    localparam motion_t MOTION_SPIN_RIGHT = 3'd6;

    localparam drive_t DRIVE_STOP     = 3'd0;
    localparam drive_t DRIVE_FORWARD  = 3'd1;
    localparam drive_t DRIVE_BACKWARD = 3'd2;
    localparam drive_t DRIVE_LEFT     = 3'd3;
    localparam drive_t DRIVE_RIGHT    = 3'd4;

    typedef struct packed {
        drive_t drive;
        speed_t drive_speed;
        logic   finished;
    } result_t;

    // Spin moves drive the same way as the plain turns.
    function automatic drive_t drive_of(motion_t m);
        drive_t d;
        case (m)
            MOTION_FORWARD:    d = DRIVE_FORWARD;
            MOTION_BACKWARD:   d = DRIVE_BACKWARD;
            MOTION_LEFT:       d = DRIVE_LEFT;
            MOTION_RIGHT:      d = DRIVE_RIGHT;
            MOTION_SPIN_LEFT:  d = DRIVE_LEFT;
            MOTION_SPIN_RIGHT: d = DRIVE_RIGHT;
            default:           d = DRIVE_STOP;
        endcase
        return d;
    endfunction

endpackage

>>> sv/tmrc_cmd_if.sv
// Command channel: valid/ready handshake carrying one input item.
interface tmrc_cmd_if;
    logic                valid;
    logic                ready;
    tmrc_pkg::kind_t     kind;
    tmrc_pkg::motion_t   motion;
    tmrc_pkg::speed_t    speed_target;
    tmrc_pkg::dur_t      run_time_ms;

    modport source (output valid, output kind, output motion, output speed_target,
                    output run_time_ms, input ready);
    modport sink   (input valid, input kind, input motion, input speed_target,
                    input run_time_ms, output ready);
endinterface

>>> sv/tmrc_res_if.sv
// Result channel: valid/ready handshake carrying one drive result item.
interface tmrc_res_if;
    logic               valid;
    logic               ready;
    tmrc_pkg::drive_t   drive;
    tmrc_pkg::speed_t   drive_speed;
    logic               finished;

    modport source (output valid, output drive, output drive_speed, output finished,
                    input ready);
    modport sink   (input valid, input drive, input drive_speed, input finished,
                    output ready);
endinterface

>>> sv/timed_motion_ramp_controller_unit.sv
// Timed motion ramp controller: move/stop/tick items in, drive results out.
//
// Takes one command item every clock cycle while cmd.ready is high. Move and
// stop items update the motion state and give no result; a tick item steps
// the ramped speed one toward the goal, advances the run timer by TICK_MS
// while moving, halts once the run time is used up, and gives one result
// item (drive, drive speed, finished). Results sit in an output register
// backed by a one-entry skid stage, so the block keeps taking items while a
// result waits; cmd.ready drops only while the skid stage holds a result,
// i.e. after a tick has arrived while the result side was stalled.
module timed_motion_ramp_controller_unit #(
    parameter int TICK_MS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    tmrc_cmd_if.sink          cmd,
    tmrc_res_if.source        res
);

    tmrc_pkg::motion_t  motion_reg,  motion_next;
    tmrc_pkg::speed_t   goal_reg,    goal_next;
    tmrc_pkg::speed_t   ramp_reg,    ramp_next;
    tmrc_pkg::dur_t     dur_reg,     dur_next;
    tmrc_pkg::elapsed_t elapsed_reg, elapsed_next;

    tmrc_pkg::result_t  out_reg, skid_reg, new_res;
    logic               out_valid_reg, skid_valid_reg;

    logic               accept;
    logic               res_fire;
    logic               take;
    tmrc_pkg::elapsed_t elapsed_sum;

    assign accept   = cmd.valid && cmd.ready;
    assign res_fire = accept && (cmd.kind == tmrc_pkg::KIND_TICK);
    assign take     = res.valid && res.ready;
    assign cmd.ready = !skid_valid_reg;

    assign elapsed_sum = elapsed_reg + tmrc_pkg::ELAPSED_W'(TICK_MS);

    always_comb
    begin
        motion_next  = motion_reg;
        goal_next    = goal_reg;
        ramp_next    = ramp_reg;
        dur_next     = dur_reg;
        elapsed_next = elapsed_reg;
        new_res.drive = tmrc_pkg::drive_of(motion_reg);

        case (cmd.kind)
            tmrc_pkg::KIND_MOVE:
            begin
                motion_next  = cmd.motion;
                goal_next    = cmd.speed_target;
                dur_next     = cmd.run_time_ms;
                elapsed_next = '0;
            end
            tmrc_pkg::KIND_STOP:
            begin
                motion_next  = tmrc_pkg::MOTION_STOP;
                goal_next    = '0;
                dur_next     = '0;
                elapsed_next = '0;
            end
            tmrc_pkg::KIND_TICK:
            begin
                if (ramp_reg < goal_reg)
                begin
                    ramp_next = ramp_reg + 1'b1;
                end
                else if (ramp_reg > goal_reg)
                begin
                    ramp_next = ramp_reg - 1'b1;
                end
                if (motion_reg != tmrc_pkg::MOTION_STOP)
                begin
                    // Halt once the run time is used up.
                    if (elapsed_sum >= {1'b0, dur_reg})
                    begin
                        motion_next  = tmrc_pkg::MOTION_STOP;
                        goal_next    = '0;
                        dur_next     = '0;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_sum;
                    end
                end
            end
            default:
            begin
            end
        endcase

        new_res.drive_speed = ramp_next;
        new_res.finished    = (motion_next == tmrc_pkg::MOTION_STOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg  <= tmrc_pkg::MOTION_STOP;
            goal_reg    <= '0;
            ramp_reg    <= '0;
            dur_reg     <= '0;
            elapsed_reg <= '0;
        end
        else if (accept)
        begin
            motion_reg  <= motion_next;
            goal_reg    <= goal_next;
            ramp_reg    <= ramp_next;
            dur_reg     <= dur_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Output register with one-entry skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !res.ready)
        begin
            skid_valid_reg <= res_fire;
        end
        else
        begin
            out_valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_valid_reg && !res.ready)
        begin
            if (res_fire)
            begin
                skid_reg <= new_res;
            end
        end
        else if (res_fire)
        begin
            out_reg <= new_res;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.drive       = out_reg.drive;
    assign res.drive_speed = out_reg.drive_speed;
    assign res.finished    = out_reg.finished;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.kind == tmrc_pkg::KIND_STOP)
        |=> (motion_reg == tmrc_pkg::MOTION_STOP) && (goal_reg == '0)
            && (elapsed_reg == '0))
        else $error("stop item did not clear the motion state");

    a_ramp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ramp_reg == $past(ramp_reg)) || (ramp_reg == $past(ramp_reg) + 8'd1)
        || (ramp_reg == $past(ramp_reg) - 8'd1))
        else $error("ramped speed moved by more than one step");

    a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (motion_reg != tmrc_pkg::MOTION_STOP) |-> (elapsed_reg <= {1'b0, dur_reg}))
        else $error("run timer passed the duration while still moving");

endmodule
